// ----- src/dbq_pkg.sv -----
// dbq_pkg: shared widths, operation and status codes, and controller states
// for the dual byte queue. No dependencies; compile first.

package dbq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DROP_W = 16;

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TX_APPEND = 3'd0,
    OP_TX_POP    = 3'd1,
    OP_RX_PUSH   = 3'd2,
    OP_RX_DRAIN  = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// ----- src/dbq_if.sv -----
// dbq_if: valid/ready channel interfaces for the command items and the
// result items of the dual byte queue. Depends on dbq_pkg.

interface dbq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dbq_pkg::OP_W-1:0]    op;
  logic [dbq_pkg::BYTE_W-1:0]  in_byte;
  logic                        first;
  logic [dbq_pkg::LEN_W-1:0]   msg_len;
  logic [dbq_pkg::LEN_W-1:0]   max_len;

  modport source (output valid, op, in_byte, first, msg_len, max_len, input ready);
  modport sink   (input valid, op, in_byte, first, msg_len, max_len, output ready);
endinterface

interface dbq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dbq_pkg::STAT_W-1:0]  status;
  logic [dbq_pkg::BYTE_W-1:0]  out_byte;
  logic [dbq_pkg::LEN_W-1:0]   drained_total;
  logic                        last;
  logic [dbq_pkg::DROP_W-1:0]  overflow_count;
  logic [dbq_pkg::LEN_W-1:0]   rx_level;
  logic [dbq_pkg::LEN_W-1:0]   tx_level;

  modport source (output valid, status, out_byte, drained_total, last, overflow_count,
                  rx_level, tx_level, input ready);
  modport sink   (input valid, status, out_byte, drained_total, last, overflow_count,
                  rx_level, tx_level, output ready);
endinterface

// ----- src/dbq_ram.sv -----
// dbq_ram: byte ring storage, one write port and one read port, read data
// registered and held while no read is issued. No package dependency.

module dbq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold last read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dual_byte_queue.sv -----
// dual_byte_queue: transmit and receive byte rings with a saturating receive
// overflow counter. Depends on dbq_pkg, dbq_if and dbq_ram.
//
// usage
//   in_i carries one command item per handshake (op, in_byte, first, msg_len,
//   max_len); out_o returns result items through a single output register
//   - tx append, rx push, clear, unused codes, empty pop and empty or zero
//     length drain: one result, registered in the cycle after the command
//   - tx pop: one result, after one ram read and the output register
//   - rx drain of n bytes: n results, the first after a ram read, then one
//     per cycle while the receiver takes them; last marks the final one,
//     levels already show the state after the whole drain
//   throughput: one command item per cycle for writes and clears while the
//   receiver takes each result; a pop or drain holds off commands until its
//   last result, bound by the registered ram read and single output register
//   ready is low while a read sequence runs or the output register is full
//   and not being taken; a stalled receiver holds the sequence in place
//   reset clears pointers, counts, pending reservation and the overflow
//   counter at once; ring contents need no clearing

module dual_byte_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbq_in_if.sink    in_i,
  dbq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // ring pointer step, base below DEPTH and offset at most DEPTH
  function automatic addr_t wrap_add(addr_t base, cnt_t off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  dbq_pkg::state_e state_q, state_d;

  // queue state
  addr_t tx_head_q, tx_head_d;
  cnt_t  tx_count_q, tx_count_d;
  cnt_t  tx_pend_q, tx_pend_d;
  addr_t rx_head_q, rx_head_d;
  cnt_t  rx_count_q, rx_count_d;
  logic [dbq_pkg::DROP_W-1:0] rx_drop_q, rx_drop_d;

  // read sequencer
  addr_t rd_ptr_q, rd_ptr_d;
  cnt_t  iss_left_q, iss_left_d;
  cnt_t  emit_left_q, emit_left_d;
  cnt_t  total_q, total_d;
  logic  src_rx_q, src_rx_d;
  logic  pend_q, pend_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [dbq_pkg::STAT_W-1:0]   out_status_q, out_status_d;
  logic [dbq_pkg::BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic [dbq_pkg::LEN_W-1:0]    out_total_q, out_total_d;
  logic                         out_last_q, out_last_d;
  logic [dbq_pkg::DROP_W-1:0]   out_drop_q, out_drop_d;
  logic [dbq_pkg::LEN_W-1:0]    out_rxl_q, out_rxl_d;
  logic [dbq_pkg::LEN_W-1:0]    out_txl_q, out_txl_d;

  logic  accept, out_free, start_read, load_single, issue, consume;
  logic  tx_we, rx_we;
  addr_t tx_waddr, rx_waddr;
  logic [dbq_pkg::STAT_W-1:0]  single_status;
  logic [dbq_pkg::BYTE_W-1:0]  tx_rdata, rx_rdata;
  logic [dbq_pkg::LEN_W+0:0]   len_sum;
  cnt_t                        drain_n;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == dbq_pkg::S_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  // read sequencer handshake with the output register
  assign consume = (state_q == dbq_pkg::S_READ) && pend_q && out_free;
  assign issue   = (state_q == dbq_pkg::S_READ) && (iss_left_q != '0) &&
                   (!pend_q || consume);

  assign len_sum = (dbq_pkg::LEN_W + 1)'(tx_count_q) + (dbq_pkg::LEN_W + 1)'(in_i.msg_len);
  assign drain_n = ((dbq_pkg::LEN_W)'(rx_count_q) < in_i.max_len) ? rx_count_q
                                                                  : CW'(in_i.max_len);

  assign tx_waddr = wrap_add(tx_head_q, tx_count_q);
  assign rx_waddr = wrap_add(rx_head_q, rx_count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbq_pkg::S_IDLE: begin
        if (accept && start_read) begin
          state_d = dbq_pkg::S_READ;
        end
      end
      dbq_pkg::S_READ: begin
        if (consume && (emit_left_q == CW'(1))) begin
          state_d = dbq_pkg::S_IDLE;
        end
      end
      default: state_d = dbq_pkg::S_IDLE;
    endcase
  end

  // command decode and queue update
  always_comb begin
    tx_head_d     = tx_head_q;
    tx_count_d    = tx_count_q;
    tx_pend_d     = tx_pend_q;
    rx_head_d     = rx_head_q;
    rx_count_d    = rx_count_q;
    rx_drop_d     = rx_drop_q;
    rd_ptr_d      = rd_ptr_q;
    iss_left_d    = iss_left_q;
    emit_left_d   = emit_left_q;
    total_d       = total_q;
    src_rx_d      = src_rx_q;
    start_read    = 1'b0;
    single_status = dbq_pkg::STAT_OK;
    tx_we         = 1'b0;
    rx_we         = 1'b0;

    if (accept) begin
      unique case (dbq_pkg::op_e'(in_i.op))
        dbq_pkg::OP_TX_APPEND: begin
          if (in_i.first) begin
            tx_pend_d = '0;
            if (len_sum > (dbq_pkg::LEN_W + 1)'(DEPTH)) begin
              single_status = dbq_pkg::STAT_REJECT;
            end else if (in_i.msg_len != '0) begin
              tx_we      = 1'b1;
              tx_count_d = tx_count_q + CW'(1);
              tx_pend_d  = CW'(in_i.msg_len) - CW'(1);
            end
          end else if (tx_pend_q == '0) begin
            // rest of a rejected or finished message
            single_status = dbq_pkg::STAT_REJECT;
          end else begin
            tx_we      = 1'b1;
            tx_count_d = tx_count_q + CW'(1);
            tx_pend_d  = tx_pend_q - CW'(1);
          end
        end
        dbq_pkg::OP_TX_POP: begin
          if (tx_count_q == '0) begin
            single_status = dbq_pkg::STAT_EMPTY;
          end else begin
            start_read  = 1'b1;
            src_rx_d    = 1'b0;
            rd_ptr_d    = tx_head_q;
            iss_left_d  = CW'(1);
            emit_left_d = CW'(1);
            total_d     = '0;
            tx_head_d   = wrap_add(tx_head_q, CW'(1));
            tx_count_d  = tx_count_q - CW'(1);
          end
        end
        dbq_pkg::OP_RX_PUSH: begin
          if (rx_count_q >= CW'(DEPTH)) begin
            single_status = dbq_pkg::STAT_REJECT;
            if (rx_drop_q != dbq_pkg::DROP_MAX) begin
              rx_drop_d = rx_drop_q + 1'b1;
            end
          end else begin
            rx_we      = 1'b1;
            rx_count_d = rx_count_q + CW'(1);
          end
        end
        dbq_pkg::OP_RX_DRAIN: begin
          if (drain_n == '0) begin
            single_status = (rx_count_q == '0) ? dbq_pkg::STAT_EMPTY : dbq_pkg::STAT_OK;
          end else begin
            start_read  = 1'b1;
            src_rx_d    = 1'b1;
            rd_ptr_d    = rx_head_q;
            iss_left_d  = drain_n;
            emit_left_d = drain_n;
            total_d     = drain_n;
            rx_head_d   = wrap_add(rx_head_q, drain_n);
            rx_count_d  = rx_count_q - drain_n;
          end
        end
        dbq_pkg::OP_CLEAR: begin
          tx_head_d  = '0;
          tx_count_d = '0;
          tx_pend_d  = '0;
          rx_head_d  = '0;
          rx_count_d = '0;
          rx_drop_d  = '0;
        end
        default: begin
          // unused codes leave everything unchanged
        end
      endcase
    end

    if (issue) begin
      rd_ptr_d   = wrap_add(rd_ptr_q, CW'(1));
      iss_left_d = iss_left_q - CW'(1);
    end
    if (consume) begin
      emit_left_d = emit_left_q - CW'(1);
    end
  end

  assign load_single = accept && !start_read;

  always_comb begin
    if (issue) begin
      pend_d = 1'b1;
    end else if (consume) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
  end

  // output register load
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;
    out_drop_d   = out_drop_q;
    out_rxl_d    = out_rxl_q;
    out_txl_d    = out_txl_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_single) begin
      out_valid_d  = 1'b1;
      out_status_d = single_status;
      out_byte_d   = '0;
      out_total_d  = '0;
      out_last_d   = 1'b1;
      out_drop_d   = rx_drop_d;
      out_rxl_d    = dbq_pkg::LEN_W'(rx_count_d);
      out_txl_d    = dbq_pkg::LEN_W'(tx_count_d);
    end else if (consume) begin
      out_valid_d  = 1'b1;
      out_status_d = dbq_pkg::STAT_OK;
      out_byte_d   = src_rx_q ? rx_rdata : tx_rdata;
      out_total_d  = dbq_pkg::LEN_W'(total_q);
      out_last_d   = (emit_left_q == CW'(1));
      out_drop_d   = rx_drop_q;
      out_rxl_d    = dbq_pkg::LEN_W'(rx_count_q);
      out_txl_d    = dbq_pkg::LEN_W'(tx_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbq_pkg::S_IDLE;
      tx_head_q   <= '0;
      tx_count_q  <= '0;
      tx_pend_q   <= '0;
      rx_head_q   <= '0;
      rx_count_q  <= '0;
      rx_drop_q   <= '0;
      iss_left_q  <= '0;
      emit_left_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_head_q   <= tx_head_d;
      tx_count_q  <= tx_count_d;
      tx_pend_q   <= tx_pend_d;
      rx_head_q   <= rx_head_d;
      rx_count_q  <= rx_count_d;
      rx_drop_q   <= rx_drop_d;
      iss_left_q  <= iss_left_d;
      emit_left_q <= emit_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    total_q      <= total_d;
    src_rx_q     <= src_rx_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_total_q  <= out_total_d;
    out_last_q   <= out_last_d;
    out_drop_q   <= out_drop_d;
    out_rxl_q    <= out_rxl_d;
    out_txl_q    <= out_txl_d;
  end

  dbq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (dbq_pkg::BYTE_W)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (in_i.in_byte),
    .re_i    (issue && !src_rx_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (tx_rdata)
  );

  dbq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (dbq_pkg::BYTE_W)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (in_i.in_byte),
    .re_i    (issue && src_rx_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (rx_rdata)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.drained_total  = out_total_q;
  assign out_o.last           = out_last_q;
  assign out_o.overflow_count = out_drop_q;
  assign out_o.rx_level       = out_rxl_q;
  assign out_o.tx_level       = out_txl_q;

  // reservation never goes beyond the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW + 1)'(tx_count_q) + (SW + 1)'(tx_pend_q) <= (SW + 1)'(DEPTH))
    else $error("tx reservation exceeds ring depth");

  // reads issued never run ahead of results still owed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbq_pkg::S_READ) |-> (emit_left_q != '0) && (iss_left_q <= emit_left_q))
    else $error("read sequencer counters out of step");

  // the final read result ends the sequence with last set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (emit_left_q == CW'(1))) |=> (state_q == dbq_pkg::S_IDLE) && out_valid_q &&
                                            out_last_q)
    else $error("read sequence did not close with a last result");

  // no command is taken while a read sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbq_pkg::S_READ) |-> !accept)
    else $error("command accepted during read sequence");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for dual_byte_queue, with random handshake idling on both channels
// expected results come from an in-bench model of both byte rings and the drop counter
// depends on dbq_pkg, dbq_if and dual_byte_queue

module tb;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned AW           = $clog2(DEPTH);
  localparam int unsigned RANDOM_ITEMS = 350;
  // a few drops past a full receive ring
  localparam int unsigned FLOOD_DROPS  = 4;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned SHOWN_ERRORS = 10;
  // far beyond the slowest legal run with every wait at its maximum
  localparam int unsigned LIMIT_TIME   = 12_000_000;

  // op codes the block treats as no-ops
  localparam logic [dbq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam int unsigned              SPARE_CODES = 3;

  typedef logic [AW-1:0] idx_t;

  typedef struct packed {
    logic [dbq_pkg::OP_W-1:0]   op;
    logic [dbq_pkg::BYTE_W-1:0] in_byte;
    logic                       first;
    logic [dbq_pkg::LEN_W-1:0]  msg_len;
    logic [dbq_pkg::LEN_W-1:0]  max_len;
  } cmd_t;

  typedef struct packed {
    logic [dbq_pkg::STAT_W-1:0] status;
    logic [dbq_pkg::BYTE_W-1:0] out_byte;
    logic [dbq_pkg::LEN_W-1:0]  drained_total;
    logic                       last;
    logic [dbq_pkg::DROP_W-1:0] overflow_count;
    logic [dbq_pkg::LEN_W-1:0]  rx_level;
    logic [dbq_pkg::LEN_W-1:0]  tx_level;
  } result_t;

  logic clk;
  logic rst_n;

  dbq_in_if  in_ch ();
  dbq_out_if out_ch ();

  dual_byte_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // pending command items, and results the model says must come out next
  cmd_t    cmd_backlog[$];
  result_t awaited_results[$];

  // model copy of the block state
  logic [dbq_pkg::BYTE_W-1:0] tx_mem [DEPTH];
  int unsigned                tx_rd;
  logic [dbq_pkg::LEN_W-1:0]  tx_cnt;
  logic [dbq_pkg::LEN_W-1:0]  tx_res;
  logic [dbq_pkg::BYTE_W-1:0] rx_mem [DEPTH];
  int unsigned                rx_rd;
  logic [dbq_pkg::LEN_W-1:0]  rx_cnt;
  logic [dbq_pkg::DROP_W-1:0] rx_drop;

  // handshake flags seen at the last rising edge, read by the falling-edge drivers
  bit in_fired;
  bit out_fired;

  // per-side wait counters and calm stretches with no idling
  int unsigned src_wait;
  int unsigned snk_wait;
  bit          src_calm;
  bit          snk_calm;

  int unsigned errors;
  int unsigned made;
  cmd_t        next_cmd;
  cmd_t        seen_cmd;
  result_t     got;
  result_t     want;

  // clock, period 2
  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned pick_wait(bit calm);
    return calm ? 0 : $urandom_range(7, 0);
  endfunction

  function automatic void queue_cmd(logic [dbq_pkg::OP_W-1:0] op, int unsigned b,
                                    int unsigned f, int unsigned ml, int unsigned mx);
    cmd_t c;
    c.op      = op;
    c.in_byte = b[dbq_pkg::BYTE_W-1:0];
    c.first   = f[0];
    c.msg_len = ml[dbq_pkg::LEN_W-1:0];
    c.max_len = mx[dbq_pkg::LEN_W-1:0];
    cmd_backlog.push_back(c);
    made++;
  endfunction

  // both rings empty, counter back to zero
  task automatic clear_queues();
    tx_rd   = 0;
    tx_cnt  = '0;
    tx_res  = '0;
    rx_rd   = 0;
    rx_cnt  = '0;
    rx_drop = '0;
  endtask

  // advance the model by one command item and queue the results it causes
  task automatic predict_queue_results(input cmd_t c);
    result_t                    r;
    logic [dbq_pkg::BYTE_W-1:0] taken[$];
    int unsigned                n;
    bit                         store;
    r        = '0;
    r.status = dbq_pkg::STAT_OK;
    r.last   = 1'b1;
    store    = 1'b0;
    n        = 0;
    case (c.op)
      dbq_pkg::OP_TX_APPEND: begin
        if (c.first) begin
          // a new first byte abandons whatever was still reserved
          tx_res = '0;
          if (int'(tx_cnt) + int'(c.msg_len) > DEPTH) begin
            r.status = dbq_pkg::STAT_REJECT;
          end else if (c.msg_len != '0) begin
            tx_res = c.msg_len;
            store  = 1'b1;
          end
        end else if (tx_res == '0) begin
          // body byte with no reservation left, also the tail of a rejected message
          r.status = dbq_pkg::STAT_REJECT;
        end else begin
          store = 1'b1;
        end
        if (store) begin
          tx_mem[idx_t'((tx_rd + tx_cnt) % DEPTH)] = c.in_byte;
          tx_cnt = tx_cnt + 1'b1;
          tx_res = tx_res - 1'b1;
        end
      end
      dbq_pkg::OP_TX_POP: begin
        if (tx_cnt == '0) begin
          r.status = dbq_pkg::STAT_EMPTY;
        end else begin
          r.out_byte = tx_mem[idx_t'(tx_rd)];
          tx_rd  = (tx_rd + 1) % DEPTH;
          tx_cnt = tx_cnt - 1'b1;
        end
      end
      dbq_pkg::OP_RX_PUSH: begin
        if (rx_cnt >= DEPTH) begin
          // full ring drops the byte, counter holds at its top
          r.status = dbq_pkg::STAT_REJECT;
          if (rx_drop != dbq_pkg::DROP_MAX) rx_drop = rx_drop + 1'b1;
        end else begin
          rx_mem[idx_t'((rx_rd + rx_cnt) % DEPTH)] = c.in_byte;
          rx_cnt = rx_cnt + 1'b1;
        end
      end
      dbq_pkg::OP_RX_DRAIN: begin
        n = (rx_cnt < c.max_len) ? int'(rx_cnt) : int'(c.max_len);
        if (n == 0) begin
          // empty ring, or a zero length drain of a non-empty one
          r.status = (rx_cnt == '0) ? dbq_pkg::STAT_EMPTY : dbq_pkg::STAT_OK;
        end else begin
          for (int i = 0; i < n; i++) taken.push_back(rx_mem[idx_t'((rx_rd + i) % DEPTH)]);
          rx_rd  = (rx_rd + n) % DEPTH;
          rx_cnt = rx_cnt - n[dbq_pkg::LEN_W-1:0];
        end
      end
      dbq_pkg::OP_CLEAR: clear_queues();
      default: begin
        // spare codes change nothing
      end
    endcase
    // levels always show the state after the whole item
    r.overflow_count = rx_drop;
    r.rx_level       = rx_cnt;
    r.tx_level       = tx_cnt;
    if (taken.size() == 0) begin
      awaited_results.push_back(r);
    end else begin
      r.drained_total = n[dbq_pkg::LEN_W-1:0];
      for (int i = 0; i < n; i++) begin
        r.out_byte = taken[i];
        r.last     = (i == n - 1);
        awaited_results.push_back(r);
      end
    end
  endtask

  task automatic note_mismatch(bit orphan, result_t exp, result_t act);
    errors++;
    if (errors <= SHOWN_ERRORS) begin
      if (orphan) begin
        $display("tb: result with nothing awaited");
        $display("tb:          got st %0d byte %0h total %0d last %0b ovf %0d rx %0d tx %0d",
                 act.status, act.out_byte, act.drained_total, act.last,
                 act.overflow_count, act.rx_level, act.tx_level);
      end else begin
        $display("tb: mismatch exp st %0d byte %0h total %0d last %0b ovf %0d rx %0d tx %0d",
                 exp.status, exp.out_byte, exp.drained_total, exp.last,
                 exp.overflow_count, exp.rx_level, exp.tx_level);
        $display("tb:          got st %0d byte %0h total %0d last %0b ovf %0d rx %0d tx %0d",
                 act.status, act.out_byte, act.drained_total, act.last,
                 act.overflow_count, act.rx_level, act.tx_level);
      end
    end
  endtask

  // monitor: sample both channels at the rising edge, check results before predicting,
  // since no result can belong to an item accepted at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired  = 1'b0;
      out_fired = 1'b0;
    end else begin
      out_fired = out_ch.valid && out_ch.ready;
      if (out_fired) begin
        got.status         = out_ch.status;
        got.out_byte       = out_ch.out_byte;
        got.drained_total  = out_ch.drained_total;
        got.last           = out_ch.last;
        got.overflow_count = out_ch.overflow_count;
        got.rx_level       = out_ch.rx_level;
        got.tx_level       = out_ch.tx_level;
        if (awaited_results.size() == 0) begin
          note_mismatch(1'b1, got, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) note_mismatch(1'b0, want, got);
        end
      end
      in_fired = in_ch.valid && in_ch.ready;
      if (in_fired) begin
        seen_cmd.op      = in_ch.op;
        seen_cmd.in_byte = in_ch.in_byte;
        seen_cmd.first   = in_ch.first;
        seen_cmd.msg_len = in_ch.msg_len;
        seen_cmd.max_len = in_ch.max_len;
        predict_queue_results(seen_cmd);
      end
    end
  end

  // command driver: hold an item until taken, then wait its drawn gap before the next
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !in_fired)) begin
        if (src_wait > 0) begin
          src_wait--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          in_ch.op      <= next_cmd.op;
          in_ch.in_byte <= next_cmd.in_byte;
          in_ch.first   <= next_cmd.first;
          in_ch.msg_len <= next_cmd.msg_len;
          in_ch.max_len <= next_cmd.max_len;
          in_ch.valid   <= 1'b1;
          if ($urandom_range(29, 0) == 0) src_calm = !src_calm;
          src_wait = pick_wait(src_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: after each taken result, stall a drawn number of cycles
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) begin
        if ($urandom_range(29, 0) == 0) snk_calm = !snk_calm;
        snk_wait = pick_wait(snk_calm);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : run
    int unsigned                kind;
    int unsigned                len;
    int unsigned                body;
    int unsigned                rnd;
    logic [dbq_pkg::OP_W-1:0]   code;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = dbq_pkg::OP_TX_APPEND;
    in_ch.in_byte = '0;
    in_ch.first   = 1'b0;
    in_ch.msg_len = '0;
    in_ch.max_len = '0;
    out_ch.ready  = 1'b0;
    errors        = 0;
    made          = 0;
    src_wait      = 0;
    snk_wait      = pick_wait(1'b0);
    src_calm      = 1'b0;
    snk_calm      = 1'b0;
    clear_queues();

    // directed: empty pops and drains, reservation corner cases, spare codes
    queue_cmd(dbq_pkg::OP_TX_POP, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, 5);
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h3C, 1, 0, $urandom);        // zero length message
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h11, 0, $urandom, $urandom); // body byte, no reservation
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'hFF, 1, 3, $urandom);
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h00, 0, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'hA5, 0, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h5A, 0, $urandom, $urandom); // past the reservation
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h77, 1, 62, $urandom);       // one place short, rejected
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h78, 0, $urandom, $urandom); // rest of rejected message
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h79, 1, 127, $urandom);      // length field at its top
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h80, 1, 61, $urandom);       // fits exactly
    queue_cmd(dbq_pkg::OP_TX_APPEND, 'h01, 1, 2, $urandom);        // abandons open reservation
    queue_cmd(dbq_pkg::OP_TX_POP, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_TX_POP, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_PUSH, 'h00, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_PUSH, 'hFF, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, 0);   // zero length, bytes held
    queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, 127); // more than held
    for (int i = 0; i < SPARE_CODES; i++)
      queue_cmd(OP_SPARE_LO + i[dbq_pkg::OP_W-1:0], $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_TX_POP, $urandom, $urandom, $urandom, $urandom);

    // flood: fill the receive ring, push a few more to count drops,
    // drain a full ring in one go, then clear and see the counter back at zero
    for (int i = 0; i < DEPTH + FLOOD_DROPS; i++)
      queue_cmd(dbq_pkg::OP_RX_PUSH, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, 64);
    queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, 64);
    queue_cmd(dbq_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(dbq_pkg::OP_RX_PUSH, $urandom, $urandom, $urandom, $urandom);

    // random: mostly well-formed tx messages and bursts, some broken and noise items
    while (made < RANDOM_ITEMS) begin
      kind = $urandom_range(99, 0);
      if (kind < 30) begin
        len = ($urandom_range(9, 0) < 8) ? $urandom_range(8, 1) : $urandom_range(127, 0);
        body = (len > 0) ? len - 1 : 0;
        // sometimes cut the message short or run past its end
        if ($urandom_range(6, 0) == 0) body = $urandom_range(body, 0);
        else if ($urandom_range(9, 0) == 0) body = body + $urandom_range(2, 1);
        queue_cmd(dbq_pkg::OP_TX_APPEND, $urandom, 1, len, $urandom);
        for (int i = 0; i < body; i++)
          queue_cmd(dbq_pkg::OP_TX_APPEND, $urandom, 0, $urandom, $urandom);
      end else if (kind < 50) begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          queue_cmd(dbq_pkg::OP_TX_POP, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 68) begin
        len = ($urandom_range(19, 0) == 0) ? 70 : $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          queue_cmd(dbq_pkg::OP_RX_PUSH, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 82) begin
        len = ($urandom_range(4, 0) == 0) ? $urandom_range(127, 0) : $urandom_range(8, 0);
        queue_cmd(dbq_pkg::OP_RX_DRAIN, $urandom, $urandom, $urandom, len);
      end else if (kind < 86) begin
        queue_cmd(dbq_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 90) begin
        rnd  = $urandom_range(SPARE_CODES - 1, 0);
        code = OP_SPARE_LO + rnd[dbq_pkg::OP_W-1:0];
        queue_cmd(code, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // noise: any code, any field values
        rnd  = $urandom;
        code = rnd[dbq_pkg::OP_W-1:0];
        queue_cmd(code, $urandom, $urandom, $urandom, $urandom);
      end
    end

    // release reset at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all items taken, then all results in, then a quiet tail for strays
    @(posedge clk);
    while (cmd_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("tb: done, errors");
    $finish;
  end

endmodule
